// File: hw/rtl/vid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vid_pkg: shared types for the vertex index deduplicator
// Holds the search token that travels down the row of lookup cells.
// ----------------------------------------------------------------------------
package vid_pkg;

    // Widest table index the block supports (65536 entries).
    localparam int unsigned MAX_AW = 16;

    // Search token handed from one lookup cell to the next in every cycle.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [MAX_AW-1:0] idx;
        logic [MAX_AW-1:0] row;
    } t_token;

endpackage

// File: hw/rtl/vid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vid_ram: generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module vid_ram #(
    parameter int unsigned WIDTH = 60,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/vid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vid_cell: one lookup cell of the search chain
// Holds every NUM_CELLS-th table entry, compares one row per token against
// the key and passes the token on to its neighbor.
// ----------------------------------------------------------------------------
module vid_cell #(
    parameter int unsigned CELL_ID   = 0,
    parameter int unsigned NUM_CELLS = 16,
    parameter int unsigned ROWS      = 256,
    parameter int unsigned KEY_W     = 60,
    parameter int unsigned AW        = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  vid_pkg::t_token                          i_tok,
    output vid_pkg::t_token                          o_tok,
    input  logic [KEY_W-1:0]                         i_key,
    input  logic [AW:0]                              i_count,
    input  logic                                     i_wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] i_wr_row,
    input  logic [KEY_W-1:0]                         i_wr_data
);

    localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW = $clog2(NUM_CELLS);
    localparam logic [CW-1:0] CID = CW'(CELL_ID);

    vid_pkg::t_token       r_tok;
    logic [KEY_W-1:0]      rd_data;
    logic [vid_pkg::MAX_AW:0] entry;
    logic                  match;

    vid_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_row),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_tok.valid),
        .i_rd_addr (i_tok.row[RW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Entry number of the row just read; only entries below the fill count
    // belong to the current mesh.
    assign entry = (vid_pkg::MAX_AW + 1)'({r_tok.row[RW-1:0], CID});
    assign match = r_tok.valid
                && (entry < (vid_pkg::MAX_AW + 1)'(i_count))
                && (rd_data == i_key);

    always_comb begin
        o_tok     = r_tok;
        o_tok.hit = r_tok.hit | match;
        if (match) begin
            o_tok.idx = vid_pkg::MAX_AW'(entry);
        end
    end

endmodule

// File: hw/rtl/vertex_index_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_index_dedup: face-corner index triple deduplicator
// Maps position/normal/texcoord index triples to dense vertex indices.
// ----------------------------------------------------------------------------
// Each input beat is one face corner. The block searches the triples stored
// since the last mesh start and returns the combined index of a match, or
// stores the triple under the next dense index and flags it as new; a miss
// with the table full stores nothing and returns only the table-full flag.
// The table is spread over a chain of NUM_CELLS lookup cells; entry e lives
// in cell e mod NUM_CELLS at row e / NUM_CELLS. A search sends one token per
// occupied row into the first cell, one per cycle, and each token moves one
// cell per cycle, so the row sweep and the length of the cell chain set how
// long an item takes. A result beat sits in an output register, so the next
// corner is accepted while it waits. A corner with first_of_mesh set empties
// the table by resetting the fill count; no clearing pass is needed and the
// block is ready right after reset. Configuration is an APB-style port with
// has_normals at address 0 and has_texcoords at address 4.
// ----------------------------------------------------------------------------
module vertex_index_dedup #(
    parameter int unsigned CAPACITY   = 4096,
    parameter int unsigned INDEX_BITS = 20,
    parameter int unsigned NUM_CELLS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Corner input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_position_index,
    input  logic [19:0] i_normal_index,
    input  logic [19:0] i_texcoord_index,
    input  logic        i_first_of_mesh,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_combined_index,
    output logic        o_is_new,
    output logic [21:0] o_position_offset,
    output logic [21:0] o_normal_offset,
    output logic [20:0] o_texcoord_offset,
    output logic [3:0]  o_floats_appended,
    output logic        o_table_full
);

    // Table geometry.
    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CW    = $clog2(NUM_CELLS);
    localparam int unsigned ROWS  = (CAPACITY + NUM_CELLS - 1) / NUM_CELLS;
    localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned RCW   = AW + 1 - CW;

    // Only the low INDEX_BITS of each 20-bit index take part.
    localparam int unsigned MB    = (INDEX_BITS < 20) ? INDEX_BITS : 20;
    localparam int unsigned KEY_W = 3 * MB;
    localparam logic [19:0] IDX_MASK = 20'((64'd1 << MB) - 64'd1);

    localparam logic [AW:0] CAP_COUNT = (AW + 1)'(CAPACITY);

    // Floats a new vertex appends to the vertex buffer.
    localparam logic [3:0] POS_FLOATS = 4'd3;
    localparam logic [3:0] NRM_FLOATS = 4'd3;
    localparam logic [3:0] TEX_FLOATS = 4'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_HAS_NORMALS   = 1'b0;
    localparam logic REG_HAS_TEXCOORDS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state r_state;

    logic r_has_normals;
    logic r_has_texcoords;

    // Current corner, already masked.
    logic [19:0] r_pos;
    logic [19:0] r_nrm;
    logic [19:0] r_tex;

    logic [AW:0]  r_count;
    logic [RCW-1:0] r_row;
    logic [RCW-1:0] r_ret;
    logic           r_hit;
    logic [vid_pkg::MAX_AW-1:0] r_hit_idx;

    // Output register.
    logic        r_out_valid;
    logic [11:0] r_combined_index;
    logic        r_is_new;
    logic [21:0] r_position_offset;
    logic [21:0] r_normal_offset;
    logic [20:0] r_texcoord_offset;
    logic [3:0]  r_floats_appended;
    logic        r_table_full;

    logic [AW:0]      n_sum;
    logic [RCW-1:0]   nrows;
    logic [KEY_W-1:0] key;
    logic             in_accept;
    logic             out_free;
    logic             full;
    logic             wr_en;
    logic [RW-1:0]    wr_row;
    logic [31:0]      found32;
    logic [3:0]       n_floats;

    vid_pkg::t_token tok [NUM_CELLS+1];

    // ------------------------------------------------------------------------
    // Configuration port. Writes land on the access cycle; a register keeps
    // only bit 0 of the written data.
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_normals   <= 1'b0;
            r_has_texcoords <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HAS_NORMALS:   r_has_normals   <= pwdata[0];
                REG_HAS_TEXCOORDS: r_has_texcoords <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HAS_NORMALS:   prdata = {31'd0, r_has_normals};
            REG_HAS_TEXCOORDS: prdata = {31'd0, r_has_texcoords};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Search control.
    // ------------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Rows that hold at least one entry of the current mesh.
    assign n_sum = r_count + (AW + 1)'(NUM_CELLS - 1);
    assign nrows = RCW'(n_sum >> CW);

    assign key = {r_pos[MB-1:0], r_nrm[MB-1:0], r_tex[MB-1:0]};

    // Token fed into the head of the chain, one row per cycle.
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = (r_state == S_SCAN) && (r_row < nrows);
        tok[0].row   = vid_pkg::MAX_AW'(r_row);
    end

    // A miss with the table at capacity stores nothing.
    assign full   = (r_count == CAP_COUNT);
    assign wr_en  = (r_state == S_DECIDE) && out_free && !r_hit && !full;
    assign wr_row = RW'(r_count >> CW);

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vid_cell #(
            .CELL_ID   (k),
            .NUM_CELLS (NUM_CELLS),
            .ROWS      (ROWS),
            .KEY_W     (KEY_W),
            .AW        (AW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok[k]),
            .o_tok     (tok[k+1]),
            .i_key     (key),
            .i_count   (r_count),
            .i_wr_en   (wr_en && (r_count[CW-1:0] == CW'(k))),
            .i_wr_row  (wr_row),
            .i_wr_data (key)
        );
    end

    // Index given to this corner, cut to the 12-bit result field.
    assign found32  = r_hit ? 32'(r_hit_idx) : 32'(r_count);
    assign n_floats = POS_FLOATS
                    + (r_has_normals   ? NRM_FLOATS : 4'd0)
                    + (r_has_texcoords ? TEX_FLOATS : 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the decide state a leaving beat is replaced by the new one.
            if (r_out_valid && i_out_ready && (r_state != S_DECIDE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_pos   <= i_position_index & IDX_MASK;
                        r_nrm   <= i_normal_index & IDX_MASK;
                        r_tex   <= i_texcoord_index & IDX_MASK;
                        r_row   <= '0;
                        r_ret   <= '0;
                        r_hit   <= 1'b0;
                        if (i_first_of_mesh) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok[0].valid) begin
                        r_row <= r_row + 1'b1;
                    end
                    if (tok[NUM_CELLS].valid) begin
                        r_ret <= r_ret + 1'b1;
                        if (tok[NUM_CELLS].hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= tok[NUM_CELLS].idx;
                        end
                    end
                    if (r_ret == nrows) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (!r_hit && full) begin
                            r_combined_index  <= '0;
                            r_is_new          <= 1'b0;
                            r_position_offset <= '0;
                            r_normal_offset   <= '0;
                            r_texcoord_offset <= '0;
                            r_floats_appended <= '0;
                            r_table_full      <= 1'b1;
                        end else begin
                            r_combined_index  <= found32[11:0];
                            r_is_new          <= !r_hit;
                            r_position_offset <= {1'b0, r_pos, 1'b0} + {2'b00, r_pos};
                            r_normal_offset   <= {1'b0, r_nrm, 1'b0} + {2'b00, r_nrm};
                            r_texcoord_offset <= {r_tex, 1'b0};
                            r_floats_appended <= r_hit ? 4'd0 : n_floats;
                            r_table_full      <= 1'b0;
                        end
                        if (wr_en) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_combined_index  = r_combined_index;
    assign o_is_new          = r_is_new;
    assign o_position_offset = r_position_offset;
    assign o_normal_offset   = r_normal_offset;
    assign o_texcoord_offset = r_texcoord_offset;
    assign o_floats_appended = r_floats_appended;
    assign o_table_full      = r_table_full;

endmodule

// File: tb/sv/vertex_index_dedup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_index_dedup_tb: self-checking bench for the vertex index deduplicator
// Drives face corners through the valid/ready input channel and checks every
// result beat against a bench-side model of the triple table. The run covers
// a directed table, random meshes under four mesh formats and a long result
// stall.
// ----------------------------------------------------------------------------
module vertex_index_dedup_tb;

    // ------------------------------------------------------------------------
    // Bench constants.
    // ------------------------------------------------------------------------
    localparam int          CLK_PERIOD     = 4;
    localparam int          RESET_CYCLES   = 9;
    localparam int          TABLE_SLOTS    = 4096;
    // The slowest corner sweeps 4096 / 16 rows plus the cell chain; this
    // settle time covers the tail of the run once nothing is due.
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          RANDOM_PHASE   = 100;
    localparam int          HOLD_OFF       = 250;

    // Register byte addresses on the configuration port.
    localparam logic [2:0]  ADDR_HAS_NORMALS   = 3'd0;
    localparam logic [2:0]  ADDR_HAS_TEXCOORDS = 3'd4;

    // Source strides and float counts of one vertex.
    localparam logic [21:0] POS_STRIDE     = 22'd3;
    localparam logic [21:0] NRM_STRIDE     = 22'd3;
    localparam logic [20:0] TEX_STRIDE     = 21'd2;
    localparam logic [3:0]  POS_FLOATS     = 4'd3;
    localparam logic [3:0]  NRM_FLOATS     = 4'd3;
    localparam logic [3:0]  TEX_FLOATS     = 4'd2;

    localparam logic [19:0] INDEX_MAX      = 20'hFFFFF;

    // ------------------------------------------------------------------------
    // One result beat, one input beat.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [11:0] combined_index;
        logic        is_new;
        logic [21:0] position_offset;
        logic [21:0] normal_offset;
        logic [20:0] texcoord_offset;
        logic [3:0]  floats_appended;
        logic        table_full;
    } t_vertex_ref;

    typedef struct {
        logic [19:0] pos;
        logic [19:0] nrm;
        logic [19:0] tex;
        logic        first_of_mesh;
        bit          typed;   // result below is written out by hand
        t_vertex_ref want;
    } t_corner;

    // ------------------------------------------------------------------------
    // DUT signals.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [19:0] i_position_index;
    logic [19:0] i_normal_index;
    logic [19:0] i_texcoord_index;
    logic        i_first_of_mesh;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_combined_index;
    logic        o_is_new;
    logic [21:0] o_position_offset;
    logic [21:0] o_normal_offset;
    logic [20:0] o_texcoord_offset;
    logic [3:0]  o_floats_appended;
    logic        o_table_full;

    vertex_index_dedup dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_position_index  (i_position_index),
        .i_normal_index    (i_normal_index),
        .i_texcoord_index  (i_texcoord_index),
        .i_first_of_mesh   (i_first_of_mesh),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_combined_index  (o_combined_index),
        .o_is_new          (o_is_new),
        .o_position_offset (o_position_offset),
        .o_normal_offset   (o_normal_offset),
        .o_texcoord_offset (o_texcoord_offset),
        .o_floats_appended (o_floats_appended),
        .o_table_full      (o_table_full)
    );

    // ------------------------------------------------------------------------
    // Bench-side table model and bookkeeping.
    // ------------------------------------------------------------------------
    // Triples stored since the last mesh start, keyed by {pos, nrm, tex},
    // holding the dense vertex index they were given.
    int unsigned vertex_of_triple [logic [59:0]];
    int unsigned vertex_count;
    logic        cfg_normals;
    logic        cfg_texcoords;

    // Result beats still owed by the block, oldest first.
    t_vertex_ref vertex_refs_due [$];

    int err_count    = 0;
    int corner_count = 0;
    int ref_count    = 0;
    int reuse_count  = 0;
    int full_count   = 0;

    // Idle shaping; the result sink picks up hold_req in its own process.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_req   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirrors one corner through the triple table. A mesh start empties the
    // table first; a hit returns the stored index; a miss either allocates
    // the next dense index or, with the table full, returns only the flag.
    function automatic t_vertex_ref dedup_corner(input logic [19:0] pos,
                                                 input logic [19:0] nrm,
                                                 input logic [19:0] tex,
                                                 input logic        first_of_mesh);
        t_vertex_ref r;
        logic [59:0] key;
        int unsigned slot;
        bit          hit;
        r   = '0;
        key = {pos, nrm, tex};
        if (first_of_mesh) begin
            vertex_of_triple.delete();
            vertex_count = 0;
        end
        hit = vertex_of_triple.exists(key);
        if (!hit && vertex_count >= TABLE_SLOTS) begin
            r.table_full = 1'b1;
            return r;
        end
        if (hit) begin
            slot = vertex_of_triple[key];
        end else begin
            slot = vertex_count;
            vertex_of_triple[key] = slot;
            vertex_count++;
            r.floats_appended = POS_FLOATS + (cfg_normals ? NRM_FLOATS : 4'd0)
                              + (cfg_texcoords ? TEX_FLOATS : 4'd0);
        end
        r.combined_index  = slot[11:0];
        r.is_new          = !hit;
        r.position_offset = {2'b00, pos} * POS_STRIDE;
        r.normal_offset   = {2'b00, nrm} * NRM_STRIDE;
        r.texcoord_offset = {1'b0, tex} * TEX_STRIDE;
        return r;
    endfunction

    function automatic t_vertex_ref mk_ref(input int idx, input bit is_new,
                                           input int po, input int no, input int to,
                                           input int fl, input bit full);
        t_vertex_ref r;
        r.combined_index  = idx[11:0];
        r.is_new          = is_new;
        r.position_offset = po[21:0];
        r.normal_offset   = no[21:0];
        r.texcoord_offset = to[20:0];
        r.floats_appended = fl[3:0];
        r.table_full      = full;
        return r;
    endfunction

    function automatic t_corner mk_corner(input logic [19:0] pos, input logic [19:0] nrm,
                                          input logic [19:0] tex, input logic fom,
                                          input bit typed, input t_vertex_ref want);
        t_corner c;
        c.pos           = pos;
        c.nrm           = nrm;
        c.tex           = tex;
        c.first_of_mesh = fom;
        c.typed         = typed;
        c.want          = want;
        return c;
    endfunction

    // Mostly back to back, a fair share of short gaps and a few long ones.
    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Index values lean on the extremes and on a small range, so that random
    // meshes reuse triples often.
    function automatic logic [19:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 20'd0;
        if (roll < 20)
            return INDEX_MAX;
        if (roll < 50)
            return 20'($urandom_range(0, 15));
        return 20'($urandom_range(0, INDEX_MAX));
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lowers valid and waits until every result beat owed has come back.
    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        while (vertex_refs_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Sets the mesh format while the block is idle. Only bit 0 of a write
    // counts, so the upper bits carry random junk; a read-back confirms it.
    task automatic set_mesh_format(input logic normals, input logic texcoords);
        logic [31:0] rd;
        wait_drained(2);
        apb_write(ADDR_HAS_NORMALS, {31'($urandom), normals});
        apb_write(ADDR_HAS_TEXCOORDS, {31'($urandom), texcoords});
        cfg_normals   = normals;
        cfg_texcoords = texcoords;
        apb_read(ADDR_HAS_NORMALS, rd);
        check_field("has_normals", {31'b0, normals}, rd);
        apb_read(ADDR_HAS_TEXCOORDS, rd);
        check_field("has_texcoords", {31'b0, texcoords}, rd);
    endtask

    // ------------------------------------------------------------------------
    // Corner source. Called just after a rising edge; returns at the edge
    // where the beat was taken. With no gap, valid simply stays high and the
    // payload moves on to the next corner.
    // ------------------------------------------------------------------------
    task automatic send_corner(input t_corner c, input int gap);
        t_vertex_ref predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_position_index <= c.pos;
        i_normal_index   <= c.nrm;
        i_texcoord_index <= c.tex;
        i_first_of_mesh  <= c.first_of_mesh;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = dedup_corner(c.pos, c.nrm, c.tex, c.first_of_mesh);
        vertex_refs_due.push_back(c.typed ? c.want : predicted);
        corner_count++;
    endtask

    // Random meshes: each starts with a mesh-start corner and draws most of
    // its corners from a small pool of indices, so hits and misses mix. The
    // rest is noise: fully random corners and stray mesh starts.
    task automatic run_meshes(input int n_items);
        logic [19:0] pos_pool [4];
        logic [19:0] nrm_pool [4];
        logic [19:0] tex_pool [4];
        t_corner     c;
        int          sent;
        int          mesh_len;
        int          k;
        sent = 0;
        while (sent < n_items) begin
            mesh_len = $urandom_range(1, 30);
            for (k = 0; k < 4; k++) begin
                pos_pool[k] = pick_index();
                nrm_pool[k] = pick_index();
                tex_pool[k] = pick_index();
            end
            for (k = 0; k < mesh_len && sent < n_items; k++) begin
                c = mk_corner('0, '0, '0, 1'b0, 1'b0, '0);
                if ($urandom_range(0, 99) < 80) begin
                    c.pos = pos_pool[$urandom_range(0, 3)];
                    c.nrm = nrm_pool[$urandom_range(0, 3)];
                    c.tex = tex_pool[$urandom_range(0, 3)];
                end else begin
                    c.pos = 20'($urandom_range(0, INDEX_MAX));
                    c.nrm = 20'($urandom_range(0, INDEX_MAX));
                    c.tex = 20'($urandom_range(0, INDEX_MAX));
                end
                c.first_of_mesh = (k == 0) || ($urandom_range(0, 99) < 3);
                send_corner(c, pick_gap(tx_idle_en));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: takes beats, compares them with the oldest result owed,
    // and shapes its own ready, including the long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int          stall_left;
        int          hold_left;
        t_vertex_ref want;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                ref_count++;
                if (vertex_refs_due.size() == 0) begin
                    $error("result beat with no corner waiting for it");
                    err_count++;
                end else begin
                    want = vertex_refs_due.pop_front();
                    if (want.table_full)
                        full_count++;
                    else if (!want.is_new)
                        reuse_count++;
                    check_field("combined_index", want.combined_index, o_combined_index);
                    check_field("is_new", want.is_new, o_is_new);
                    check_field("position_offset", want.position_offset,
                                o_position_offset);
                    check_field("normal_offset", want.normal_offset, o_normal_offset);
                    check_field("texcoord_offset", want.texcoord_offset,
                                o_texcoord_offset);
                    check_field("floats_appended", want.floats_appended,
                                o_floats_appended);
                    check_field("table_full", want.table_full, o_table_full);
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap(rx_idle_en);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no beat moves on either channel for too
    // long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_corner directed_rows [$];
        int      r;
        i_clk            = 1'b0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_position_index <= '0;
        i_normal_index   <= '0;
        i_texcoord_index <= '0;
        i_first_of_mesh  <= 1'b0;
        vertex_count     = 0;
        cfg_normals      = 1'b0;
        cfg_texcoords    = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners under the reset format (position floats only).
        // Rows with a result written out are the obvious ones: the zero and
        // the all-ones triples, their reuse, and mesh starts that empty the
        // table. The rest, single-field differences among them, use the model.
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd0, 1'b1, 1'b1,
                                          mk_ref(0, 1, 0, 0, 0, 3, 0)));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd0, 1'b0, 1'b1,
                                          mk_ref(0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(mk_corner(INDEX_MAX, INDEX_MAX, INDEX_MAX, 1'b0, 1'b1,
                                mk_ref(1, 1, 3145725, 3145725, 2097150, 3, 0)));
        directed_rows.push_back(mk_corner(INDEX_MAX, INDEX_MAX, INDEX_MAX, 1'b0, 1'b1,
                                mk_ref(1, 0, 3145725, 3145725, 2097150, 0, 0)));
        directed_rows.push_back(mk_corner(INDEX_MAX, 20'd0, 20'd0, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'd0, INDEX_MAX, 20'd0, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, INDEX_MAX, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'd1, 20'd0, 20'd0, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd1, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd0, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'hAAAAA, 20'h55555, 20'h12345, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'h55555, 20'hAAAAA, 20'hEDCBA, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'hAAAAA, 20'h55555, 20'h12345, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(INDEX_MAX, INDEX_MAX, INDEX_MAX, 1'b1, 1'b1,
                                mk_ref(0, 1, 3145725, 3145725, 2097150, 3, 0)));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd0, 1'b0, 1'b1,
                                          mk_ref(1, 1, 0, 0, 0, 3, 0)));
        directed_rows.push_back(mk_corner(20'd0, 20'd0, 20'd0, 1'b1, 1'b1,
                                          mk_ref(0, 1, 0, 0, 0, 3, 0)));
        directed_rows.push_back(mk_corner(INDEX_MAX, INDEX_MAX, INDEX_MAX, 1'b0, 1'b0, '0));
        directed_rows.push_back(mk_corner(20'hAAAAA, 20'h55555, 20'h12345, 1'b0, 1'b0, '0));
        for (r = 0; r < directed_rows.size(); r++)
            send_corner(directed_rows[r], pick_gap(tx_idle_en));

        // Random meshes under each mesh format. The second format runs with
        // no idling on either side.
        set_mesh_format(1'b1, 1'b0);
        run_meshes(RANDOM_PHASE);

        set_mesh_format(1'b0, 1'b1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_meshes(RANDOM_PHASE);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Long result stall with corners offered back to back, so the block
        // backs up and has to stall its input.
        set_mesh_format(1'b1, 1'b1);
        hold_req = HOLD_OFF;
        tx_idle_en = 1'b0;
        run_meshes(24);
        tx_idle_en = 1'b1;
        run_meshes(RANDOM_PHASE - 24);

        set_mesh_format(1'b0, 1'b0);
        run_meshes(RANDOM_PHASE);

        wait_drained(DRAIN_CYCLES);

        $display("Covered %0d corners and %0d result beats: %0d reused, %0d table-full.",
                 corner_count, ref_count, reuse_count, full_count);
        $display("Mesh formats: all four flag settings, idle and back-to-back traffic, %s",
                 "a long result stall.");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vid_pkg.sv
hw/rtl/vid_ram.sv
hw/rtl/vid_cell.sv
hw/rtl/vertex_index_dedup.sv
tb/sv/vertex_index_dedup_tb.sv
